// ----- rtl/dis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types, codes and reset values of the display idle saver controller.
// ----------------------------------------------------------------------------
package dis_pkg;

  // Display saver state as reported on the result stream.
  typedef enum logic [1:0] {
    SAVER_AWAKE = 2'd0,
    SAVER_DIM   = 2'd1,
    SAVER_OFF   = 2'd2
  } saver_e;

  // Saver mode codes held in the per-application mode registers.
  // The unused code behaves as dim.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_DIM  = 2'd1;
  localparam logic [1:0] MODE_OFF  = 2'd2;

  // Request kinds.
  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_KEY    = 2'd1;
  localparam logic [1:0] REQ_MANUAL = 2'd2;

  // Application states; anything above error forbids the saver.
  localparam logic [2:0] APP_BROWSING = 3'd0;
  localparam logic [2:0] APP_RECORDING = 3'd1;
  localparam logic [2:0] APP_PLAYING  = 3'd2;
  localparam logic [2:0] APP_ERROR    = 3'd3;

  // A key code of zero is counted as a question mark.
  localparam logic [7:0] KEY_NONE     = 8'h00;
  localparam logic [7:0] KEY_FALLBACK = 8'h3F;

  // Configuration register map (word index).
  localparam int unsigned APB_ADDR_W = 5;
  localparam logic [2:0] REG_IDLE_MODE      = 3'd0;
  localparam logic [2:0] REG_RECORDING_MODE = 3'd1;
  localparam logic [2:0] REG_PLAYBACK_MODE  = 3'd2;
  localparam logic [2:0] REG_TRIPLE_WAKE    = 3'd3;
  localparam logic [2:0] REG_IDLE_DELAY     = 3'd4;
  localparam logic [2:0] REG_ACTIVE_DELAY   = 3'd5;
  localparam logic [2:0] REG_DIM_LEVEL      = 3'd6;
  localparam logic [2:0] REG_USER_LEVEL     = 3'd7;

  // Register reset values.
  localparam logic [1:0]  RST_IDLE_MODE      = 2'd1;
  localparam logic [1:0]  RST_RECORDING_MODE = 2'd1;
  localparam logic [1:0]  RST_PLAYBACK_MODE  = 2'd1;
  localparam logic        RST_TRIPLE_WAKE    = 1'b0;
  localparam logic [31:0] RST_IDLE_DELAY     = 32'd30000;
  localparam logic [31:0] RST_ACTIVE_DELAY   = 32'd10000;
  localparam logic [7:0]  RST_DIM_LEVEL      = 8'd16;
  localparam logic [7:0]  RST_USER_LEVEL     = 8'd128;

  typedef struct packed {
    logic [1:0]  idle_mode;
    logic [1:0]  recording_mode;
    logic [1:0]  playback_mode;
    logic        triple_wake_enable;
    logic [31:0] idle_delay_ms;
    logic [31:0] active_delay_ms;
    logic [7:0]  dim_level;
    logic [7:0]  user_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] app_state;
    logic [7:0] key_code;
  } item_t;

  typedef struct packed {
    saver_e      saver;
    logic        manual_entered;
    logic [7:0]  confirm_key;
    logic [1:0]  confirm_count;
    logic [31:0] ms_since_activity;
    logic [31:0] ms_since_confirm_press;
  } state_t;

  typedef struct packed {
    logic [1:0] saver_state;
    logic [7:0] brightness;
    logic       panel_on;
    logic       redraw;
    logic [1:0] wake_count;
    logic       manual_flag;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/dis_apb_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_apb_regs
// APB register file holding the saver modes, delays and brightness levels.
// ----------------------------------------------------------------------------
module dis_apb_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [dis_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output dis_pkg::cfg_t                         cfg_o
);

  dis_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dis_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_mode          <= dis_pkg::RST_IDLE_MODE;
      cfg_q.recording_mode     <= dis_pkg::RST_RECORDING_MODE;
      cfg_q.playback_mode      <= dis_pkg::RST_PLAYBACK_MODE;
      cfg_q.triple_wake_enable <= dis_pkg::RST_TRIPLE_WAKE;
      cfg_q.idle_delay_ms      <= dis_pkg::RST_IDLE_DELAY;
      cfg_q.active_delay_ms    <= dis_pkg::RST_ACTIVE_DELAY;
      cfg_q.dim_level          <= dis_pkg::RST_DIM_LEVEL;
      cfg_q.user_level         <= dis_pkg::RST_USER_LEVEL;
    end else if (wr_en) begin
      case (reg_idx)
        dis_pkg::REG_IDLE_MODE:      cfg_q.idle_mode          <= pwdata[1:0];
        dis_pkg::REG_RECORDING_MODE: cfg_q.recording_mode     <= pwdata[1:0];
        dis_pkg::REG_PLAYBACK_MODE:  cfg_q.playback_mode      <= pwdata[1:0];
        dis_pkg::REG_TRIPLE_WAKE:    cfg_q.triple_wake_enable <= pwdata[0];
        dis_pkg::REG_IDLE_DELAY:     cfg_q.idle_delay_ms      <= pwdata;
        dis_pkg::REG_ACTIVE_DELAY:   cfg_q.active_delay_ms    <= pwdata;
        dis_pkg::REG_DIM_LEVEL:      cfg_q.dim_level          <= pwdata[7:0];
        dis_pkg::REG_USER_LEVEL:     cfg_q.user_level         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dis_pkg::REG_IDLE_MODE:      prdata = {30'd0, cfg_q.idle_mode};
      dis_pkg::REG_RECORDING_MODE: prdata = {30'd0, cfg_q.recording_mode};
      dis_pkg::REG_PLAYBACK_MODE:  prdata = {30'd0, cfg_q.playback_mode};
      dis_pkg::REG_TRIPLE_WAKE:    prdata = {31'd0, cfg_q.triple_wake_enable};
      dis_pkg::REG_IDLE_DELAY:     prdata = cfg_q.idle_delay_ms;
      dis_pkg::REG_ACTIVE_DELAY:   prdata = cfg_q.active_delay_ms;
      dis_pkg::REG_DIM_LEVEL:      prdata = {24'd0, cfg_q.dim_level};
      dis_pkg::REG_USER_LEVEL:     prdata = {24'd0, cfg_q.user_level};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/dis_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dis_step
// Next-state and result logic for one tick, key press or manual request.
// ----------------------------------------------------------------------------
module dis_step #(
  parameter int unsigned WAKE_TIMEOUT_MS = 3000,
  parameter int unsigned WAKE_PRESSES    = 3
) (
  input  dis_pkg::cfg_t    cfg_i,
  input  dis_pkg::state_t  state_i,
  input  dis_pkg::item_t   item_i,
  output dis_pkg::state_t  state_o,
  output dis_pkg::result_t result_o
);

  localparam logic [31:0] TimeoutMs = 32'(WAKE_TIMEOUT_MS);
  localparam logic [1:0]  Presses   = 2'(WAKE_PRESSES);

  always_comb begin
    dis_pkg::state_t s;
    logic            redraw;
    logic [1:0]      mode;
    logic            allowed;
    logic [31:0]     delay;
    logic [7:0]      key;

    s      = state_i;
    redraw = 1'b0;

    case (item_i.app_state)
      dis_pkg::APP_RECORDING: mode = cfg_i.recording_mode;
      dis_pkg::APP_PLAYING:   mode = cfg_i.playback_mode;
      default:                mode = cfg_i.idle_mode;
    endcase
    allowed = (item_i.app_state <= dis_pkg::APP_ERROR);
    delay   = (item_i.app_state == dis_pkg::APP_RECORDING ||
               item_i.app_state == dis_pkg::APP_PLAYING) ?
              cfg_i.active_delay_ms : cfg_i.idle_delay_ms;
    key     = (item_i.key_code != dis_pkg::KEY_NONE) ? item_i.key_code
                                                     : dis_pkg::KEY_FALLBACK;

    case (item_i.req_type)
      dis_pkg::REQ_TICK: begin
        if (s.ms_since_activity != '1) s.ms_since_activity = s.ms_since_activity + 32'd1;
        if (s.ms_since_confirm_press != '1) begin
          s.ms_since_confirm_press = s.ms_since_confirm_press + 32'd1;
        end
        // A wake sequence whose gap has lapsed falls back to the saver.
        if (s.saver != dis_pkg::SAVER_AWAKE && s.confirm_count != 2'd0 &&
            s.ms_since_confirm_press > TimeoutMs) begin
          s.confirm_key            = '0;
          s.confirm_count          = '0;
          s.ms_since_confirm_press = '0;
          if (mode == dis_pkg::MODE_OFF) begin
            s.saver = dis_pkg::SAVER_OFF;
            redraw  = 1'b0;
          end else begin
            redraw = 1'b1;
          end
        end
        if (!allowed) begin
          if (s.saver != dis_pkg::SAVER_AWAKE) begin
            s.saver                  = dis_pkg::SAVER_AWAKE;
            s.confirm_key            = '0;
            s.confirm_count          = '0;
            s.ms_since_confirm_press = '0;
            redraw                   = 1'b1;
          end
          s.ms_since_activity = '0;
          s.manual_entered    = 1'b0;
        end else if (s.saver == dis_pkg::SAVER_AWAKE && mode != dis_pkg::MODE_NONE &&
                     s.ms_since_activity >= delay) begin
          s.manual_entered         = 1'b0;
          s.confirm_key            = '0;
          s.confirm_count          = '0;
          s.ms_since_confirm_press = '0;
          if (mode == dis_pkg::MODE_OFF) begin
            s.saver = dis_pkg::SAVER_OFF;
            redraw  = 1'b0;
          end else begin
            s.saver = dis_pkg::SAVER_DIM;
            redraw  = 1'b1;
          end
        end
      end
      dis_pkg::REQ_KEY: begin
        s.ms_since_activity = '0;
        if (s.saver != dis_pkg::SAVER_AWAKE) begin
          if (cfg_i.triple_wake_enable) begin
            if (s.confirm_count == 2'd0 || state_i.ms_since_confirm_press > TimeoutMs ||
                s.confirm_key != key) begin
              s.confirm_key   = key;
              s.confirm_count = 2'd1;
            end else if (s.confirm_count < Presses) begin
              s.confirm_count = s.confirm_count + 2'd1;
            end
            s.ms_since_confirm_press = '0;
            if (s.saver == dis_pkg::SAVER_OFF) s.saver = dis_pkg::SAVER_DIM;
          end
          if (!cfg_i.triple_wake_enable || s.confirm_count >= Presses) begin
            s.saver                  = dis_pkg::SAVER_AWAKE;
            s.manual_entered         = 1'b0;
            s.confirm_key            = '0;
            s.confirm_count          = '0;
            s.ms_since_confirm_press = '0;
          end
          redraw = 1'b1;
        end
      end
      dis_pkg::REQ_MANUAL: begin
        if (allowed && mode != dis_pkg::MODE_NONE) begin
          s.manual_entered         = 1'b1;
          s.confirm_key            = '0;
          s.confirm_count          = '0;
          s.ms_since_confirm_press = '0;
          if (mode == dis_pkg::MODE_OFF) begin
            s.saver = dis_pkg::SAVER_OFF;
            redraw  = 1'b0;
          end else begin
            s.saver = dis_pkg::SAVER_DIM;
            redraw  = 1'b1;
          end
        end
      end
      default: ;
    endcase

    state_o = s;

    result_o.saver_state = s.saver;
    case (s.saver)
      dis_pkg::SAVER_AWAKE: result_o.brightness = cfg_i.user_level;
      dis_pkg::SAVER_DIM:   result_o.brightness = cfg_i.dim_level;
      default:              result_o.brightness = 8'd0;
    endcase
    result_o.panel_on    = (s.saver != dis_pkg::SAVER_OFF);
    result_o.redraw      = redraw;
    result_o.wake_count  = s.confirm_count;
    result_o.manual_flag = s.manual_entered;
  end

endmodule
`default_nettype wire

// ----- rtl/display_idle_saver_controller.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// display_idle_saver_controller
// Screen saver controller with awake, dim and off states for a display panel.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis stream. tuser carries the request kind
//   (tick of one millisecond, key press, manual saver request); tdata carries
//   the application state and the key code. For every request the block
//   returns exactly one result on the m_axis stream: saver state, backlight
//   brightness, panel power, redraw request, wake press count and the manual
//   flag, all taken after the request has been applied.
//   An accepted request is held in the input register while the update logic
//   works on it, and moves into the result register when that register is
//   free or being emptied. One request is taken every cycle while the result
//   stream is not stalled; the controller state is a single set of registers
//   updated as a request moves into the result register, so consecutive
//   requests see each other's effect at once.
//   When the receiver stalls, the result is held, the input register keeps
//   one more request and tready drops until the result is taken.
//   Reset empties both registers, puts the panel awake with no wake sequence
//   and zeroed timers, and loads the default saver modes, delays and levels.
//   The APB port writes the registers; it is meant to be written while no
//   request is in flight.
// ----------------------------------------------------------------------------
module display_idle_saver_controller #(
  parameter int unsigned WAKE_TIMEOUT_MS = 3000,
  parameter int unsigned WAKE_PRESSES    = 3
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request stream.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] app_state, [10:3] key_code, [15:11] zero.
  input  wire logic [15:0]                    s_axis_tdata,
  // [1:0] req_type.
  input  wire logic [1:0]                     s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [1:0] saver_state, [9:2] brightness, [10] panel_on, [11] redraw,
  // [13:12] wake_count, [14] manual_flag, [15] zero.
  output logic      [15:0]                    m_axis_tdata,
  // Configuration port.
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dis_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready
);

  dis_pkg::cfg_t    cfg;
  dis_pkg::state_t  state_q, state_d;
  dis_pkg::item_t   item_q;
  dis_pkg::result_t result_d, result_q;
  logic             in_valid_q;
  logic             out_valid_q;
  logic             advance;

  dis_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dis_step #(
    .WAKE_TIMEOUT_MS (WAKE_TIMEOUT_MS),
    .WAKE_PRESSES    (WAKE_PRESSES)
  ) u_step (
    .cfg_i    (cfg),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The held request moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.req_type  <= s_axis_tuser;
      item_q.app_state <= s_axis_tdata[2:0];
      item_q.key_code  <= s_axis_tdata[10:3];
    end
  end

  // Controller state commits together with the result it produced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.saver                  <= dis_pkg::SAVER_AWAKE;
      state_q.manual_entered         <= 1'b0;
      state_q.confirm_key            <= '0;
      state_q.confirm_count          <= '0;
      state_q.ms_since_activity      <= '0;
      state_q.ms_since_confirm_press <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, result_q.manual_flag, result_q.wake_count, result_q.redraw,
                          result_q.panel_on, result_q.brightness, result_q.saver_state};

  // A stalled result must freeze the controller state.
  a_state_frozen_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(state_q))
    else $error("controller state changed while the result was stalled");

  // The panel is powered in every state except off, and dark while off.
  a_panel_matches_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.panel_on == (result_q.saver_state != dis_pkg::SAVER_OFF)) &&
                    ((result_q.saver_state != dis_pkg::SAVER_OFF) ||
                     (result_q.brightness == 8'd0)))
    else $error("panel power or brightness disagrees with saver state");

  // A pending wake sequence or a manual entry exists only while the saver runs.
  a_saver_only_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.confirm_count != 2'd0 || state_q.manual_entered) |->
      (state_q.saver != dis_pkg::SAVER_AWAKE))
    else $error("wake count or manual flag set while awake");

  // A result appears only from a request that was held in the input register.
  a_result_has_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result produced without a request");

endmodule
`default_nettype wire
